// ===== rtl/core/cfpp_pkg.sv =====
package cfpp_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

  // configuration register indexes and reset values
  localparam logic [1:0]  CFG_LOWEST_MAJOR  = 2'd0;
  localparam logic [1:0]  CFG_HIGHEST_MAJOR = 2'd1;
  localparam logic [1:0]  CFG_STRICT_MAJOR  = 2'd2;
  localparam logic [15:0] LOWEST_MAJOR_RST  = 16'd45;
  localparam logic [15:0] HIGHEST_MAJOR_RST = 16'd63;
  localparam logic [15:0] STRICT_MAJOR_RST  = 16'd56;

  localparam logic [15:0] MINOR_ALL_ONES = 16'hFFFF;
  localparam logic [7:0]  UTF8_BAD_LOW   = 8'hF0;
  localparam logic [7:0]  MH_KIND_MAX    = 8'd9;

  // event kinds
  localparam logic [1:0] EV_ENTRY = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_NO_MINOR  = 3'd2;
  localparam logic [2:0] ERR_NO_MAJOR  = 3'd3;
  localparam logic [2:0] ERR_BAD_MAJOR = 3'd4;
  localparam logic [2:0] ERR_BAD_MINOR = 3'd5;
  localparam logic [2:0] ERR_NO_COUNT  = 3'd6;
  localparam logic [2:0] ERR_CONSTANT  = 3'd7;

  // constant pool tags
  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;
  localparam logic [7:0] TAG_MHANDLE    = 8'd15;
  localparam logic [7:0] TAG_MTYPE      = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC    = 8'd17;
  localparam logic [7:0] TAG_INVDYN     = 8'd18;
  localparam logic [7:0] TAG_MODULE     = 8'd19;
  localparam logic [7:0] TAG_PACKAGE    = 8'd20;

  typedef enum logic [3:0] {
    ST_MAGIC,
    ST_MINOR,
    ST_MAJOR,
    ST_COUNT,
    ST_TAG,
    ST_BODY,
    ST_ULEN,
    ST_UBYTES,
    ST_DONE,
    ST_FAILED
  } stage_t;

  typedef struct packed {
    logic [15:0] lowest_major;
    logic [15:0] highest_major;
    logic [15:0] strict_major;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [15:0] entry;
    logic [7:0]  tag;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [15:0] minor;
    logic [15:0] major;
    logic        last;
  } res_t;

  // results caused by one accepted beat, in order
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_pair_t;

  // body length in bytes after the tag, zero for utf8 or an unknown tag
  function automatic logic [3:0] body_len(input logic [7:0] tag);
    logic [3:0] len;
    case (tag)
      TAG_CLASS, TAG_STRING, TAG_MTYPE, TAG_MODULE, TAG_PACKAGE: len = 4'd2;
      TAG_MHANDLE: len = 4'd3;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
      TAG_NAMETYPE, TAG_DYNAMIC, TAG_INVDYN: len = 4'd4;
      TAG_LONG, TAG_DOUBLE: len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [2:0] code,
                                  input logic [15:0] entry, input logic [7:0] tag,
                                  input logic [31:0] w1, input logic [31:0] w2);
    res_t r;
    r.kind  = kind;
    r.code  = code;
    r.entry = entry;
    r.tag   = tag;
    r.w1    = w1;
    r.w2    = w2;
    r.minor = '0;
    r.major = '0;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/cfpp_parse.sv =====
module cfpp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  input  cfpp_pkg::cfg_t     cfg,
  output cfpp_pkg::res_pair_t res
);

  cfpp_pkg::stage_t stage_r, stage_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [15:0] pool_r, pool_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] minor_r, minor_nxt;
  logic [15:0] major_r, major_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= cfpp_pkg::ST_MAGIC;
      cnt_r   <= '0;
      shift_r <= '0;
      pool_r  <= '0;
      slot_r  <= 16'd1;
      tag_r   <= '0;
      rem_r   <= '0;
      minor_r <= '0;
      major_r <= '0;
    end else begin
      stage_r <= stage_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      pool_r  <= pool_nxt;
      slot_r  <= slot_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      minor_r <= minor_nxt;
      major_r <= major_nxt;
    end
  end

  logic [63:0] tk_shift;
  logic [3:0]  cnt_inc;
  logic [3:0]  need;
  logic        tk_done;
  logic [2:0]  tk_cnt;
  logic [16:0] cmp_next;
  logic        cmp_last;
  logic [15:0] fa, fc;
  logic        ok_a, ok_c;
  logic [15:0] rem_dec;

  // shared field assembly
  always_comb begin
    tk_shift = {shift_r[55:0], data_byte};
    cnt_inc  = {1'b0, cnt_r} + 4'd1;
    case (stage_r)
      cfpp_pkg::ST_MAGIC: need = 4'd4;
      cfpp_pkg::ST_BODY:  need = cfpp_pkg::body_len(tag_r);
      default:            need = 4'd2;
    endcase
    tk_done  = cnt_inc >= need;
    tk_cnt   = tk_done ? 3'd0 : cnt_inc[2:0];
    fa       = tk_shift[31:16];
    fc       = tk_shift[15:0];
    ok_a     = (fa != 16'd0) && (fa < pool_r);
    ok_c     = (fc != 16'd0) && (fc < pool_r);
    cmp_next = {1'b0, slot_r} +
               (((tag_r == cfpp_pkg::TAG_LONG) || (tag_r == cfpp_pkg::TAG_DOUBLE)) ?
                17'd2 : 17'd1);
    cmp_last = cmp_next >= {1'b0, pool_r};
    rem_dec  = rem_r - 16'd1;
  end

  logic        do_cmp, do_fail;
  logic [31:0] cw1, cw2;
  logic [2:0]  fcode;
  logic [15:0] fentry;
  logic [7:0]  ftag;
  logic        p0v, p1v, p2v;
  cfpp_pkg::res_t p0, p1, p2;

  always_comb begin
    stage_nxt = stage_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    pool_nxt  = pool_r;
    slot_nxt  = slot_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    minor_nxt = minor_r;
    major_nxt = major_r;
    do_cmp  = 1'b0;
    do_fail = 1'b0;
    cw1     = '0;
    cw2     = '0;
    fcode   = cfpp_pkg::ERR_NONE;
    fentry  = '0;
    ftag    = '0;
    p0v = 1'b0;
    p1v = 1'b0;
    p2v = 1'b0;
    p0  = '0;
    p1  = '0;
    p2  = '0;

    if (beat) begin
      case (stage_r)
        cfpp_pkg::ST_MAGIC: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            if (tk_shift[31:0] != cfpp_pkg::MAGIC_WORD) begin
              do_fail = 1'b1;
              fcode   = cfpp_pkg::ERR_MAGIC;
            end else begin
              shift_nxt = '0;
              stage_nxt = cfpp_pkg::ST_MINOR;
            end
          end
        end
        cfpp_pkg::ST_MINOR: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            minor_nxt = fc;
            shift_nxt = '0;
            stage_nxt = cfpp_pkg::ST_MAJOR;
          end
        end
        cfpp_pkg::ST_MAJOR: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            major_nxt = fc;
            shift_nxt = '0;
            if ((fc < cfg.lowest_major) || (fc > cfg.highest_major)) begin
              do_fail = 1'b1;
              fcode   = cfpp_pkg::ERR_BAD_MAJOR;
            end else if ((fc >= cfg.strict_major) && (minor_r != 16'd0) &&
                         (minor_r != cfpp_pkg::MINOR_ALL_ONES)) begin
              do_fail = 1'b1;
              fcode   = cfpp_pkg::ERR_BAD_MINOR;
            end else begin
              stage_nxt = cfpp_pkg::ST_COUNT;
            end
          end
        end
        cfpp_pkg::ST_COUNT: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            pool_nxt  = fc;
            shift_nxt = '0;
            slot_nxt  = 16'd1;
            if (fc <= 16'd1) begin
              stage_nxt = cfpp_pkg::ST_DONE;
              p0v = 1'b1;
              p0  = cfpp_pkg::mk_res(cfpp_pkg::EV_DONE, cfpp_pkg::ERR_NONE, '0, '0, '0, '0);
            end else begin
              stage_nxt = cfpp_pkg::ST_TAG;
            end
          end
        end
        cfpp_pkg::ST_TAG: begin
          tag_nxt   = data_byte;
          shift_nxt = '0;
          cnt_nxt   = '0;
          if (data_byte == cfpp_pkg::TAG_UTF8) begin
            stage_nxt = cfpp_pkg::ST_ULEN;
          end else if (cfpp_pkg::body_len(data_byte) == 4'd0) begin
            do_fail = 1'b1;
            fcode   = cfpp_pkg::ERR_CONSTANT;
            fentry  = slot_r;
            ftag    = data_byte;
          end else begin
            stage_nxt = cfpp_pkg::ST_BODY;
          end
        end
        cfpp_pkg::ST_BODY: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            fentry = slot_r;
            ftag   = tag_r;
            fcode  = cfpp_pkg::ERR_CONSTANT;
            case (tag_r)
              cfpp_pkg::TAG_INTEGER, cfpp_pkg::TAG_FLOAT: begin
                do_cmp = 1'b1;
                cw1    = tk_shift[31:0];
              end
              cfpp_pkg::TAG_LONG, cfpp_pkg::TAG_DOUBLE: begin
                do_cmp = 1'b1;
                cw1    = tk_shift[63:32];
                cw2    = tk_shift[31:0];
              end
              cfpp_pkg::TAG_CLASS, cfpp_pkg::TAG_STRING, cfpp_pkg::TAG_MTYPE,
              cfpp_pkg::TAG_MODULE, cfpp_pkg::TAG_PACKAGE: begin
                do_cmp  = ok_c;
                do_fail = !ok_c;
                cw1     = {16'd0, fc};
              end
              cfpp_pkg::TAG_MHANDLE: begin
                // reference kind 1..9 sits in the byte above the index
                do_cmp  = ok_c && (tk_shift[23:16] != 8'd0) &&
                          (tk_shift[23:16] <= cfpp_pkg::MH_KIND_MAX);
                do_fail = !do_cmp;
                cw1     = {24'd0, tk_shift[23:16]};
                cw2     = {16'd0, fc};
              end
              cfpp_pkg::TAG_DYNAMIC, cfpp_pkg::TAG_INVDYN: begin
                do_cmp  = ok_c;
                do_fail = !ok_c;
                cw1     = {16'd0, fa};
                cw2     = {16'd0, fc};
              end
              default: begin
                do_cmp  = ok_a && ok_c;
                do_fail = !(ok_a && ok_c);
                cw1     = {16'd0, fa};
                cw2     = {16'd0, fc};
              end
            endcase
          end
        end
        cfpp_pkg::ST_ULEN: begin
          shift_nxt = tk_shift;
          cnt_nxt   = tk_cnt;
          if (tk_done) begin
            rem_nxt   = fc;
            shift_nxt = {48'd0, fc};
            if (fc == 16'd0) begin
              do_cmp = 1'b1;
            end else begin
              stage_nxt = cfpp_pkg::ST_UBYTES;
            end
          end
        end
        cfpp_pkg::ST_UBYTES: begin
          if ((data_byte == 8'd0) || (data_byte >= cfpp_pkg::UTF8_BAD_LOW)) begin
            do_fail = 1'b1;
            fcode   = cfpp_pkg::ERR_CONSTANT;
            fentry  = slot_r;
            ftag    = tag_r;
          end else begin
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              do_cmp = 1'b1;
              cw1    = {16'd0, shift_r[15:0]};
            end
          end
        end
        default: begin
        end
      endcase

      if (do_cmp) begin
        p0v       = 1'b1;
        p0        = cfpp_pkg::mk_res(cfpp_pkg::EV_ENTRY, cfpp_pkg::ERR_NONE, slot_r, tag_r,
                                     cw1, cw2);
        shift_nxt = '0;
        cnt_nxt   = '0;
        if (cmp_last) begin
          stage_nxt = cfpp_pkg::ST_DONE;
          p1v = 1'b1;
          p1  = cfpp_pkg::mk_res(cfpp_pkg::EV_DONE, cfpp_pkg::ERR_NONE, '0, '0, '0, '0);
        end else begin
          slot_nxt  = cmp_next[15:0];
          stage_nxt = cfpp_pkg::ST_TAG;
        end
      end else if (do_fail) begin
        stage_nxt = cfpp_pkg::ST_FAILED;
        p0v = 1'b1;
        p0  = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, fcode, fentry, ftag, '0, '0);
      end

      // truncation: the first missing item is reported
      if (end_of_file) begin
        p2v = 1'b1;
        case (stage_nxt)
          cfpp_pkg::ST_MAGIC:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_MAGIC, '0, '0, '0, '0);
          cfpp_pkg::ST_MINOR:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_NO_MINOR, '0, '0, '0, '0);
          cfpp_pkg::ST_MAJOR:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_NO_MAJOR, '0, '0, '0, '0);
          cfpp_pkg::ST_COUNT:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_NO_COUNT, '0, '0, '0, '0);
          cfpp_pkg::ST_TAG:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_CONSTANT, slot_nxt, '0,
                                  '0, '0);
          cfpp_pkg::ST_BODY, cfpp_pkg::ST_ULEN, cfpp_pkg::ST_UBYTES:
            p2 = cfpp_pkg::mk_res(cfpp_pkg::EV_ERROR, cfpp_pkg::ERR_CONSTANT, slot_nxt,
                                  tag_nxt, '0, '0);
          default:
            p2v = 1'b0;
        endcase
      end
    end

    // p1 only follows p0, and p1 with p2 never happen together
    res.v0 = p0v || p2v;
    res.v1 = p0v && (p1v || p2v);
    res.r0 = p0v ? p0 : p2;
    res.r1 = p1v ? p1 : p2;
    res.r0.minor = minor_nxt;
    res.r0.major = major_nxt;
    res.r1.minor = minor_nxt;
    res.r1.major = major_nxt;
    res.r0.last  = !res.v1;
    res.r1.last  = 1'b1;

    // a new file starts after the final byte
    if (beat && end_of_file) begin
      stage_nxt = cfpp_pkg::ST_MAGIC;
      cnt_nxt   = '0;
      shift_nxt = '0;
      pool_nxt  = '0;
      slot_nxt  = 16'd1;
      tag_nxt   = '0;
      rem_nxt   = '0;
      minor_nxt = '0;
      major_nxt = '0;
    end
  end

endmodule

// ===== rtl/core/cfpp_outq.sv =====
module cfpp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cfpp_pkg::res_pair_t res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output cfpp_pkg::res_t      head
);

  localparam int Depth = 3;

  cfpp_pkg::res_t q_r [Depth];
  cfpp_pkg::res_t q_nxt [Depth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] cnt_pop;
  logic [1:0] n_push;

  assign out_valid = cnt_r != 2'd0;
  assign head      = q_r[0];
  assign room      = cnt_r <= 2'd1;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_pop = cnt_r - {1'b0, pop};
    n_push  = push ? ({1'b0, res.v0} + {1'b0, res.v1}) : 2'd0;
    cnt_nxt = cnt_pop + n_push;
    for (int i = 0; i < Depth; i++) begin
      q_nxt[i] = (pop && (i < Depth - 1)) ? q_r[(i + 1) % Depth] : q_r[i];
      if (push && res.v0 && (cnt_pop == 2'(i))) begin
        q_nxt[i] = res.r0;
      end
      if (push && res.v1 && ((cnt_pop + 2'd1) == 2'(i))) begin
        q_nxt[i] = res.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== rtl/core/class_file_constant_pool_parser.sv =====
// Class file constant pool parser. Takes a class file one byte per input
// beat, big-endian, last byte marked by in_tlast. It checks the magic word,
// the major version against the configured window and, from the configured
// strict major upward, that the minor is 0 or 65535; then it reads the pool
// count and every tagged entry, giving one result beat per completed entry
// and one success beat after the last (long and double take two slots).
// Errors (bad magic or version, truncation, unknown tag, bad index, bad handle
// kind, bad utf8 byte) give one error beat; later bytes of that file are
// dropped silently, and the byte with in_tlast always restarts the parser for
// a new file. Rate: one byte per clock while in_tready is high. Each byte is
// parsed in the cycle it is accepted and its results land in a three-entry
// result queue that drives out_* directly, so results are registered before
// they appear. in_tready is high while at most one result waits; a byte that
// causes two results (an entry plus success or error) gives two output beats.
// out_tlast marks the final result caused by a byte. Configuration writes
// take effect at once and are meant for idle times only.
module class_file_constant_pool_parser (
  input  logic         clk,
  input  logic         rst_n,
  // input stream: tdata = data_byte[7:0]; tlast = end_of_file
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: error_code[2:0], entry_number[18:3], entry_tag[26:19],
  //        first_word[58:27], second_word[90:59], minor_version[106:91],
  //        major_version[122:107], zero fill[127:123]
  output logic [127:0] out_tdata,
  // tuser: event_kind[1:0]
  output logic [1:0]   out_tuser,
  // tlast: last_of_run
  output logic         out_tlast,
  // configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  cfpp_pkg::cfg_t      cfg_r;
  cfpp_pkg::res_pair_t res;
  cfpp_pkg::res_t      head;
  logic                beat;

  // configuration registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lowest_major  <= cfpp_pkg::LOWEST_MAJOR_RST;
      cfg_r.highest_major <= cfpp_pkg::HIGHEST_MAJOR_RST;
      cfg_r.strict_major  <= cfpp_pkg::STRICT_MAJOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfpp_pkg::CFG_LOWEST_MAJOR:  cfg_r.lowest_major  <= cfg_wdata;
        cfpp_pkg::CFG_HIGHEST_MAJOR: cfg_r.highest_major <= cfg_wdata;
        cfpp_pkg::CFG_STRICT_MAJOR:  cfg_r.strict_major  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign beat = in_tvalid && in_tready;

  cfpp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .data_byte   (in_tdata),
    .end_of_file (in_tlast),
    .cfg         (cfg_r),
    .res         (res)
  );

  cfpp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat),
    .res       (res),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {5'd0, head.major, head.minor, head.w2, head.w1, head.tag,
                      head.entry, head.code};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
